### hw/rtl/pl_pkg.sv
// package for the positional list engine
// holds sizes, request and status codes and the cell control struct; no dependencies
package pl_pkg;

  localparam int CAPACITY = 16;
  localparam int DATA_W   = 32;
  localparam int POS_W    = 5;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_SEARCH = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2
  } cell_op_t;

  typedef struct packed {
    cell_op_t                  op;
    logic [CMP_W-1:0]          pos;
    logic signed [DATA_W-1:0]  value;
    logic [CMP_W-1:0]          count;
  } cell_ctrl_t;

endpackage

### hw/rtl/pl_if.sv
// valid/ready channel interfaces for requests and results
// depends on pl_pkg
interface pl_in_if import pl_pkg::*; ();
  logic                      valid;
  logic                      ready;
  action_t                   action;
  logic signed [DATA_W-1:0]  value;
  logic [POS_W-1:0]          position;

  modport source (output valid, action, value, position, input ready);
  modport sink   (input valid, action, value, position, output ready);
endinterface

interface pl_out_if import pl_pkg::*; ();
  logic              valid;
  logic              ready;
  status_t           status;
  logic              found;
  logic [POS_W-1:0]  count;

  modport source (output valid, status, found, count, input ready);
  modport sink   (input valid, status, found, count, output ready);
endinterface

### hw/rtl/pl_cell.sv
// one list cell: holds a single entry, shifts from its neighbours and matches the key
// depends on pl_pkg
module pl_cell
  import pl_pkg::*;
(
  input  logic                      clk,
  input  logic [IDX_W-1:0]          idx_i,
  input  cell_ctrl_t                ctrl_i,
  input  logic signed [DATA_W-1:0]  left_i,
  input  logic signed [DATA_W-1:0]  right_i,
  input  logic                      found_i,
  output logic signed [DATA_W-1:0]  entry_o,
  output logic                      found_o
);

  logic signed [DATA_W-1:0] entry_r;
  logic signed [DATA_W-1:0] entry_nxt;
  logic [CMP_W-1:0]         idx_ext;

  assign idx_ext = CMP_W'(idx_i);

  always_comb begin
    entry_nxt = entry_r;
    case (ctrl_i.op)
      OP_INSERT: begin
        if (idx_ext > ctrl_i.pos) begin
          entry_nxt = left_i;
        end else if (idx_ext == ctrl_i.pos) begin
          entry_nxt = ctrl_i.value;
        end
      end
      OP_DELETE: begin
        if (idx_ext >= ctrl_i.pos) begin
          entry_nxt = right_i;
        end
      end
      default: entry_nxt = entry_r;
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry_o = entry_r;
  assign found_o = found_i | ((idx_ext < ctrl_i.count) && (entry_r == ctrl_i.value));

endmodule

### hw/rtl/positional_list_engine.sv
// Positional list engine: an ordered list of up to CAPACITY signed 32-bit values held in
// a row of cells, one entry per cell. Insert, delete, search and clear each take one
// transaction and give one result transaction with status, found flag and count. All cells
// shift or compare together in the cycle a request is accepted. One request can be taken
// every cycle unless a held result is uncollected; the result sits in an output register
// and the next request is taken while it is collected. No clearing pass after reset.
// depends on pl_pkg, pl_if and pl_cell
module positional_list_engine
  import pl_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  pl_in_if.sink      in_ch,
  pl_out_if.source   out_ch
);

  logic [CNT_W-1:0]          count_r;
  logic [CNT_W-1:0]          count_nxt;
  logic                      out_valid_r;
  status_t                   status_r;
  logic                      found_r;
  logic [POS_W-1:0]          out_count_r;
  logic                      in_fire;
  status_t                   status_nxt;
  cell_ctrl_t                ctrl;
  logic [CMP_W-1:0]          pos_ext;
  logic [CMP_W-1:0]          count_ext;
  logic [CMP_W-1:0]          count_nxt_ext;
  logic signed [DATA_W-1:0]  entry [CAPACITY];
  logic [CAPACITY:0]         found_chain;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign pos_ext     = CMP_W'(in_ch.position);
  assign count_ext   = CMP_W'(count_r);

  always_comb begin
    ctrl.op    = OP_HOLD;
    ctrl.pos   = pos_ext;
    ctrl.value = in_ch.value;
    ctrl.count = count_ext;
    status_nxt = ST_DONE;
    count_nxt  = count_r;
    case (in_ch.action)
      ACT_INSERT: begin
        if ((count_ext >= CMP_W'(CAPACITY)) || (pos_ext > count_ext)) begin
          status_nxt = ST_RANGE;
        end else begin
          ctrl.op   = in_fire ? OP_INSERT : OP_HOLD;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      ACT_DELETE: begin
        if (count_r == '0) begin
          status_nxt = ST_EMPTY;
        end else if (pos_ext >= count_ext) begin
          status_nxt = ST_RANGE;
        end else begin
          ctrl.op   = in_fire ? OP_DELETE : OP_HOLD;
          count_nxt = count_r - CNT_W'(1);
        end
      end
      ACT_CLEAR: count_nxt = '0;
      default:   count_nxt = count_r;
    endcase
  end

  assign count_nxt_ext = CMP_W'(count_nxt);
  assign found_chain[0] = 1'b0;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [DATA_W-1:0] left_d;
    logic signed [DATA_W-1:0] right_d;
    if (g == 0) begin : g_head
      assign left_d = in_ch.value;
    end else begin : g_mid_l
      assign left_d = entry[g-1];
    end
    if (g == CAPACITY - 1) begin : g_tail
      assign right_d = '0;
    end else begin : g_mid_r
      assign right_d = entry[g+1];
    end
    pl_cell u_cell (
      .clk     (clk),
      .idx_i   (IDX_W'(g)),
      .ctrl_i  (ctrl),
      .left_i  (left_d),
      .right_i (right_d),
      .found_i (found_chain[g]),
      .entry_o (entry[g]),
      .found_o (found_chain[g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      status_r    <= status_nxt;
      found_r     <= (in_ch.action == ACT_SEARCH) && found_chain[CAPACITY];
      out_count_r <= count_nxt_ext[POS_W-1:0];
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.status = status_r;
  assign out_ch.found  = found_r;
  assign out_ch.count  = out_count_r;

endmodule
